FILE: hdl/assert_macros.svh
// Assertion macros shared by the circle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  `ASSERT_AT(lbl, clk, rst, !(cond))

`endif

FILE: hdl/cttp_pkg.sv
// Types and constants of the circle through three points block.
package cttp_pkg;

  localparam int CoordW = 12;
  localparam int OutW   = 28;
  localparam int NumW   = 43;
  localparam int DenW   = 27;
  localparam int RootW  = 29;
  localparam int SqW    = 2 * RootW;

  localparam logic [1:0] StValid = 2'd0;
  localparam logic [1:0] StColl  = 2'd1;
  localparam logic [1:0] StSat   = 2'd2;

  localparam logic signed [OutW-1:0] CtrMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] CtrMin = {1'b1, {(OutW-1){1'b0}}};
  localparam logic [OutW-1:0]        RadMax = {OutW{1'b1}};

  typedef struct packed {
    logic [CoordW-1:0] first_x;
    logic [CoordW-1:0] first_y;
    logic [CoordW-1:0] second_x;
    logic [CoordW-1:0] second_y;
    logic [CoordW-1:0] third_x;
    logic [CoordW-1:0] third_y;
  } points_t;

  typedef struct packed {
    logic signed [OutW-1:0] center_x;
    logic signed [OutW-1:0] center_y;
    logic [OutW-1:0]        radius;
    logic [1:0]             status;
  } circle_t;

  // Item handed from front to back.
  typedef struct packed {
    logic                   coll;
    logic [CoordW-1:0]      x1;
    logic [CoordW-1:0]      y1;
    logic signed [NumW-1:0] nx;
    logic signed [NumW-1:0] ny;
    logic signed [DenW-1:0] det;
  } mid_t;

  localparam int SideW = 1 + 2 * CoordW;

endpackage

FILE: hdl/cttp_fifo.sv
// Small register queue with registered storage.
module cttp_fifo #(
  parameter int W     = 8,
  parameter int Depth = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  `include "assert_macros.svh"

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [W-1:0]    mem [Depth];
  logic [PtrW-1:0] wp;
  logic [PtrW-1:0] rp;
  logic [CntW-1:0] cnt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt == CntW'(Depth));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= (wp == PtrW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (do_pop) rp <= (rp == PtrW'(Depth - 1)) ? '0 : rp + 1'b1;
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= wr_data;
  end

  `ASSERT_NEVER(a_cnt_range, clk, rst, cnt > CntW'(Depth))
  `ASSERT_AT(a_cnt_up, clk, rst, do_push && !do_pop |=> cnt == $past(cnt) + 1'b1)
endmodule

FILE: hdl/cttp_front.sv
// Front pipeline: differences, squares, determinant and centre numerators.
module cttp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cttp_pkg::points_t points,
  output logic              full,
  output logic              mid_push,
  output cttp_pkg::mid_t    mid_item,
  input  logic              mid_full
);
  import cttp_pkg::*;

  logic [4:0]              v;
  logic                    en;
  points_t                 pt;
  logic [CoordW-1:0]       x1_2, y1_2, x1_3, y1_3, x1_4, y1_4;
  logic signed [CoordW:0]  a2, b2, c2, d2, a3, b3, c3, d3;
  logic [2*CoordW-1:0]     sx1, sx2, sx3, sy1, sy2, sy3;
  logic signed [25:0]      e2, f2, ad, bc;
  logic signed [DenW-1:0]  det4;
  logic signed [38:0]      de, bf, af, ce;

  assign en       = !(v[4] && mid_full);
  assign full     = !en;
  assign mid_push = v[4] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt   <= points;
      a2   <= $signed({1'b0, pt.first_x}) - $signed({1'b0, pt.second_x});
      b2   <= $signed({1'b0, pt.first_y}) - $signed({1'b0, pt.second_y});
      c2   <= $signed({1'b0, pt.first_x}) - $signed({1'b0, pt.third_x});
      d2   <= $signed({1'b0, pt.first_y}) - $signed({1'b0, pt.third_y});
      sx1  <= pt.first_x * pt.first_x;
      sx2  <= pt.second_x * pt.second_x;
      sx3  <= pt.third_x * pt.third_x;
      sy1  <= pt.first_y * pt.first_y;
      sy2  <= pt.second_y * pt.second_y;
      sy3  <= pt.third_y * pt.third_y;
      x1_2 <= pt.first_x;
      y1_2 <= pt.first_y;
      e2   <= $signed({2'b0, sx1}) - $signed({2'b0, sx2})
            + $signed({2'b0, sy1}) - $signed({2'b0, sy2});
      f2   <= $signed({2'b0, sx1}) - $signed({2'b0, sx3})
            + $signed({2'b0, sy1}) - $signed({2'b0, sy3});
      ad   <= a2 * d2;
      bc   <= b2 * c2;
      a3   <= a2;
      b3   <= b2;
      c3   <= c2;
      d3   <= d2;
      x1_3 <= x1_2;
      y1_3 <= y1_2;
      det4 <= {ad[25], ad} - {bc[25], bc};
      de   <= d3 * e2;
      bf   <= b3 * f2;
      af   <= a3 * f2;
      ce   <= c3 * e2;
      x1_4 <= x1_3;
      y1_4 <= y1_3;
      mid_item.coll <= (det4 == '0);
      mid_item.x1   <= x1_4;
      mid_item.y1   <= y1_4;
      mid_item.nx   <= {({de[38], de} - {bf[38], bf}), 3'b000};
      mid_item.ny   <= {({af[38], af} - {ce[38], ce}), 3'b000};
      mid_item.det  <= det4;
    end
  end
endmodule

FILE: hdl/cttp_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
module cttp_div #(
  parameter int SW = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [SW-1:0]                    in_side,
  input  logic signed [cttp_pkg::NumW-1:0] nx,
  input  logic signed [cttp_pkg::NumW-1:0] ny,
  input  logic signed [cttp_pkg::DenW-1:0] den,
  output logic                             out_vld,
  output logic [SW-1:0]                    out_side,
  output logic [cttp_pkg::NumW-1:0]        qx,
  output logic [cttp_pkg::NumW-1:0]        qy,
  output logic                             negx,
  output logic                             negy
);
  import cttp_pkg::*;

  typedef struct packed {
    logic [SW-1:0]   side;
    logic            negx;
    logic            negy;
    logic [DenW-1:0] dm;
    logic [DenW-1:0] remx;
    logic [DenW-1:0] remy;
    logic [NumW-1:0] nqx;
    logic [NumW-1:0] nqy;
  } dst_t;

  function automatic dst_t div_step(dst_t s);
    dst_t          o;
    logic [DenW:0] tx;
    logic [DenW:0] ty;
    logic          gx;
    logic          gy;
    o  = s;
    tx = {s.remx, s.nqx[NumW-1]};
    ty = {s.remy, s.nqy[NumW-1]};
    gx = tx >= {1'b0, s.dm};
    gy = ty >= {1'b0, s.dm};
    o.remx = gx ? DenW'(tx - {1'b0, s.dm}) : tx[DenW-1:0];
    o.remy = gy ? DenW'(ty - {1'b0, s.dm}) : ty[DenW-1:0];
    o.nqx  = {s.nqx[NumW-2:0], gx};
    o.nqy  = {s.nqy[NumW-2:0], gy};
    return o;
  endfunction

  dst_t          st [NumW+1];
  logic [NumW:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NumW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].side <= in_side;
      st[0].negx <= nx[NumW-1] ^ den[DenW-1];
      st[0].negy <= ny[NumW-1] ^ den[DenW-1];
      st[0].dm   <= den[DenW-1] ? DenW'(-den) : DenW'(den);
      st[0].remx <= '0;
      st[0].remy <= '0;
      st[0].nqx  <= nx[NumW-1] ? NumW'(-nx) : NumW'(nx);
      st[0].nqy  <= ny[NumW-1] ? NumW'(-ny) : NumW'(ny);
    end
  end

  for (genvar k = 1; k <= NumW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) st[k] <= div_step(st[k-1]);
    end
  end

  assign out_vld  = vld[NumW];
  assign out_side = st[NumW].side;
  assign qx       = st[NumW].nqx;
  assign qy       = st[NumW].nqy;
  assign negx     = st[NumW].negx;
  assign negy     = st[NumW].negy;
endmodule

FILE: hdl/cttp_back.sv
// Back pipeline: centre division, clamping, squared distance and square root.
module cttp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              mid_vld,
  input  cttp_pkg::mid_t    mid_item,
  output logic              mid_pop,
  output logic              res_push,
  output cttp_pkg::circle_t res,
  input  logic              res_full
);
  import cttp_pkg::*;
  `include "assert_macros.svh"

  localparam int Chain = 5 + RootW + 1;

  typedef struct packed {
    logic                   coll;
    logic                   sat;
    logic signed [OutW-1:0] cxc;
    logic signed [OutW-1:0] cyc;
  } side_t;

  typedef struct packed {
    side_t           sd;
    logic            big;
    logic [29:0]     rem;
    logic [RootW-1:0] root;
    logic [SqW-1:0]  val;
  } sst_t;

  function automatic sst_t sq_step(sst_t s);
    sst_t        o;
    logic [31:0] t;
    logic [31:0] tr;
    logic        ge;
    o  = s;
    t  = {s.rem, s.val[SqW-1:SqW-2]};
    tr = {1'b0, s.root, 2'b01};
    ge = t >= tr;
    o.rem  = ge ? 30'(t - tr) : t[29:0];
    o.root = {s.root[RootW-2:0], ge};
    o.val  = {s.val[SqW-3:0], 2'b00};
    return o;
  endfunction

  logic                   en;
  logic                   dv;
  logic [SideW-1:0]       dside;
  logic [NumW-1:0]        qx, qy;
  logic                   negx, negy;
  logic [Chain-1:0]       vb;

  logic                   coll1, coll2, coll3, coll4;
  logic [CoordW-1:0]      x1_1, y1_1;
  logic signed [NumW:0]   cx, cy;
  logic signed [NumW+1:0] ex, ey;
  logic [NumW+1:0]        dx, dy;
  logic                   sat2, sat3, sat4;
  logic signed [OutW-1:0] cxc2, cyc2, cxc3, cyc3, cxc4, cyc4;
  logic [2*OutW-1:0]      px, py;
  logic                   big4;
  logic                   hix, lox, hiy, loy;
  sst_t                   ss [RootW+1];
  sst_t                   sl;

  assign en       = !(vb[Chain-1] && res_full);
  assign mid_pop  = en && mid_vld;
  assign res_push = vb[Chain-1] && en;

  cttp_div #(.SW(SideW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (mid_vld),
    .in_side  ({mid_item.coll, mid_item.x1, mid_item.y1}),
    .nx       (mid_item.nx),
    .ny       (mid_item.ny),
    .den      (mid_item.det),
    .out_vld  (dv),
    .out_side (dside),
    .qx       (qx),
    .qy       (qy),
    .negx     (negx),
    .negy     (negy)
  );

  assign hix = !cx[NumW] && (cx[NumW-1:OutW-1] != '0);
  assign lox = cx[NumW] && (cx[NumW-1:OutW-1] != '1);
  assign hiy = !cy[NumW] && (cy[NumW-1:OutW-1] != '0);
  assign loy = cy[NumW] && (cy[NumW-1:OutW-1] != '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[Chain-2:0], dv};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coll1 <= dside[SideW-1];
      x1_1  <= dside[2*CoordW-1:CoordW];
      y1_1  <= dside[CoordW-1:0];
      cx    <= negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      cy    <= negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

      coll2 <= coll1;
      ex    <= $signed({{(NumW+2-CoordW-4){1'b0}}, x1_1, 4'b0000}) - {cx[NumW], cx};
      ey    <= $signed({{(NumW+2-CoordW-4){1'b0}}, y1_1, 4'b0000}) - {cy[NumW], cy};
      sat2  <= hix || lox || hiy || loy;
      cxc2  <= hix ? CtrMax : (lox ? CtrMin : cx[OutW-1:0]);
      cyc2  <= hiy ? CtrMax : (loy ? CtrMin : cy[OutW-1:0]);

      coll3 <= coll2;
      sat3  <= sat2;
      cxc3  <= cxc2;
      cyc3  <= cyc2;
      dx    <= ex[NumW+1] ? (NumW+2)'(-ex) : (NumW+2)'(ex);
      dy    <= ey[NumW+1] ? (NumW+2)'(-ey) : (NumW+2)'(ey);

      coll4 <= coll3;
      sat4  <= sat3;
      cxc4  <= cxc3;
      cyc4  <= cyc3;
      big4  <= (dx[NumW+1:OutW] != '0) || (dy[NumW+1:OutW] != '0);
      px    <= dx[OutW-1:0] * dx[OutW-1:0];
      py    <= dy[OutW-1:0] * dy[OutW-1:0];

      ss[0].sd.coll <= coll4;
      ss[0].sd.sat  <= sat4;
      ss[0].sd.cxc  <= cxc4;
      ss[0].sd.cyc  <= cyc4;
      ss[0].big     <= big4;
      ss[0].rem     <= '0;
      ss[0].root    <= '0;
      ss[0].val     <= {2'b00, px} + {2'b00, py};
    end
  end

  for (genvar k = 1; k <= RootW; k++) begin : g_root
    always_ff @(posedge clk) begin
      if (en) ss[k] <= sq_step(ss[k-1]);
    end
  end

  assign sl = ss[RootW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (sl.sd.coll) begin
        res.center_x <= '0;
        res.center_y <= '0;
        res.radius   <= '0;
        res.status   <= StColl;
      end else begin
        res.center_x <= sl.sd.cxc;
        res.center_y <= sl.sd.cyc;
        res.radius   <= (sl.big || sl.root[RootW-1]) ? RadMax : sl.root[OutW-1:0];
        res.status   <= (sl.sd.sat || sl.big || sl.root[RootW-1]) ? StSat : StValid;
      end
    end
  end

  `ASSERT_AT(a_stall_cause, clk, rst, !en |-> vb[Chain-1] && res_full)
  `ASSERT_AT(a_status_code, clk, rst,
             res_push |-> res.status == StValid || res.status == StColl || res.status == StSat)
endmodule

FILE: hdl/circle_through_three_points.sv
// Top level: circle through three points, front/back pipelines joined by a queue.
//
//   channel  | handshake         | payload
//   points   | push / full       | three pixel points, 12-bit unsigned coords
//   circle   | empty / pop       | centre x, y (1/16 px, signed), radius, status
//
// One item per cycle sustained unless a full queue stalls a pipeline.
// Path: 5 front stages, the queue, 44 divider stages, 4 distance
// stages, 30 square-root stages, one output register and the output queue.
// Reset (rst, synchronous) empties both queues and all pipeline valids.
// Each half stalls only when its own queue is full; full drops as soon as the
// front pipeline can advance.
module circle_through_three_points (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cttp_pkg::points_t points,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output cttp_pkg::circle_t circle
);
  import cttp_pkg::*;
  `include "assert_macros.svh"

  logic    mid_push, mid_full, mid_empty, mid_pop;
  mid_t    mid_in, mid_out;
  logic    res_push, res_full;
  circle_t res;

  cttp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .points   (points),
    .full     (full),
    .mid_push (mid_push),
    .mid_item (mid_in),
    .mid_full (mid_full)
  );

  cttp_fifo #(.W($bits(mid_t)), .Depth(4)) u_midq (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (mid_in),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_out),
    .empty   (mid_empty)
  );

  cttp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_vld  (!mid_empty),
    .mid_item (mid_out),
    .mid_pop  (mid_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  cttp_fifo #(.W($bits(circle_t)), .Depth(2)) u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (circle),
    .empty   (empty)
  );

  `ASSERT_AT(a_coll_zero, clk, rst,
             !empty && circle.status == StColl |-> circle.radius == '0 && circle.center_x == '0)
endmodule

FILE: tb/tb_circle_through_three_points.sv
// Testbench for the circle through three points block: fixed and random triples vs a predictor.
`timescale 1ns / 1ps

class circle_scoreboard;
  cttp_pkg::circle_t pending_circles[$];
  int unsigned errors;
  int unsigned reported;

  function longint trunc_div(longint num, longint den);
    longint q;
    q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function longint floor_sqrt(longint v);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function cttp_pkg::circle_t fit_circle(cttp_pkg::points_t p);
    cttp_pkg::circle_t r;
    longint x1, y1, x2, y2, x3, y3, a, b, c, d, e2, f2, det, cx, cy, dx, dy;
    bit sat;
    x1 = p.first_x; y1 = p.first_y; x2 = p.second_x;
    y2 = p.second_y; x3 = p.third_x; y3 = p.third_y;
    a = x1 - x2; b = y1 - y2; c = x1 - x3; d = y1 - y3;
    e2 = (x1 * x1 - x2 * x2) + (y1 * y1 - y2 * y2);
    f2 = (x1 * x1 - x3 * x3) + (y1 * y1 - y3 * y3);
    det = a * d - b * c;
    r = '0;
    if (det == 0) begin
      r.status = cttp_pkg::StColl;
      return r;
    end
    cx = trunc_div(8 * (d * e2 - b * f2), det);
    cy = trunc_div(8 * (a * f2 - c * e2), det);
    dx = 16 * x1 - cx;
    dy = 16 * y1 - cy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sat = 0;
    if (dx >= 64'd268435456 || dy >= 64'd268435456) begin
      r.radius = cttp_pkg::RadMax;
      sat = 1;
    end else begin
      dx = floor_sqrt(dx * dx + dy * dy);
      if (dx > 64'd268435455) begin
        r.radius = cttp_pkg::RadMax;
        sat = 1;
      end else begin
        r.radius = dx[27:0];
      end
    end
    if (cx > 64'sd134217727) begin r.center_x = cttp_pkg::CtrMax; sat = 1; end
    else if (cx < -64'sd134217728) begin r.center_x = cttp_pkg::CtrMin; sat = 1; end
    else r.center_x = cx[27:0];
    if (cy > 64'sd134217727) begin r.center_y = cttp_pkg::CtrMax; sat = 1; end
    else if (cy < -64'sd134217728) begin r.center_y = cttp_pkg::CtrMin; sat = 1; end
    else r.center_y = cy[27:0];
    r.status = sat ? cttp_pkg::StSat : cttp_pkg::StValid;
    return r;
  endfunction

  function void note_points(cttp_pkg::points_t p);
    pending_circles.push_back(fit_circle(p));
  endfunction

  function void check_circle(cttp_pkg::circle_t got);
    cttp_pkg::circle_t want;
    if (pending_circles.size() == 0) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("unexpected circle %h", got);
      end
      return;
    end
    want = pending_circles.pop_front();
    if (got.center_x !== want.center_x || got.center_y !== want.center_y ||
        got.radius !== want.radius || got.status !== want.status) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("circle mismatch: exp cx=%0d cy=%0d r=%0d st=%0d got cx=%0d cy=%0d r=%0d st=%0d",
                 want.center_x, want.center_y, want.radius, want.status,
                 got.center_x, got.center_y, got.radius, got.status);
      end
    end
  endfunction
endclass

module tb_circle_through_three_points;
  import cttp_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic full;
  logic empty;
  points_t points = '0;
  circle_t circle;

  circle_scoreboard sb = new();
  bit sending_done = 0;

  circle_through_three_points i_dut (
    .clk(clk), .rst(rst), .push(push), .points(points), .full(full),
    .empty(empty), .pop(pop), .circle(circle)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CoordW'($urandom_range(0, 15));
      3: return CoordW'($urandom_range(4080, 4095));
      default: return CoordW'($urandom);
    endcase
  endfunction

  task automatic send_points(points_t p);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    points <= p;
    do @(posedge clk); while (full);
    sb.note_points(p);
  endtask

  task automatic drain_results();
    push <= 0;
    while (sb.pending_circles.size() != 0) @(posedge clk);
  endtask

  function points_t rand_triple();
    points_t p;
    p.first_x = rand_coord(); p.first_y = rand_coord();
    p.second_x = rand_coord(); p.second_y = rand_coord();
    p.third_x = rand_coord(); p.third_y = rand_coord();
    case ($urandom_range(0, 9))
      0: begin p.second_x = p.first_x; p.second_y = p.first_y; end
      1: begin
        p.second_x = p.first_x + 12'd1; p.second_y = p.first_y + 12'd1;
        p.third_x = p.first_x + 12'd2; p.third_y = p.first_y + 12'd2;
      end
      2: begin p.second_x = p.first_x; p.third_x = p.first_x; end
      3: begin
        p.second_x = p.first_x + 12'd1; p.second_y = p.first_y + 12'd1;
        p.third_x = p.first_x + 12'd2; p.third_y = p.first_y + 12'd3;
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    points_t p;
    repeat (12) @(posedge clk);
    rst <= 0;
    send_points('{12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095});
    send_points('{12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0});
    send_points('{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0});
    send_points('{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095});
    send_points('{12'd0, 12'd0, 12'd1, 12'd1, 12'd4095, 12'd4095});
    send_points('{12'd10, 12'd10, 12'd10, 12'd10, 12'd20, 12'd30});
    send_points('{12'd0, 12'd0, 12'd1, 12'd0, 12'd4095, 12'd1});
    send_points('{12'd0, 12'd0, 12'd4095, 12'd1, 12'd4094, 12'd0});
    send_points('{12'd100, 12'd0, 12'd0, 12'd100, 12'd200, 12'd100});
    send_points('{12'd0, 12'd0, 12'd3, 12'd0, 12'd0, 12'd1});
    send_points('{12'd2048, 12'd0, 12'd2049, 12'd1, 12'd2050, 12'd3});
    send_points('{12'd0, 12'd4095, 12'd1, 12'd4095, 12'd4095, 12'd4094});
    drain_results();
    for (int i = 0; i < 2000; i++) begin
      if (i == 1000) drain_results();
      p = rand_triple();
      send_points(p);
    end
    push <= 0;
    sending_done = 1;
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1;
      do @(posedge clk); while (empty);
      sb.check_circle(circle);
    end
  end

  initial begin
    wait (sending_done);
    while (sb.pending_circles.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
